/* design/idll_pkg.sv */
// ---------------------------------------------------------------------------
// Indexed doubly linked list package
// Operation codes, status codes and sequencer states shared by the list unit.
// ---------------------------------------------------------------------------
package idll_pkg;

  localparam logic [3:0] OP_PUSH_FRONT = 4'd0;
  localparam logic [3:0] OP_PUSH_BACK  = 4'd1;
  localparam logic [3:0] OP_POP_FRONT  = 4'd2;
  localparam logic [3:0] OP_POP_BACK   = 4'd3;
  localparam logic [3:0] OP_INSERT     = 4'd4;
  localparam logic [3:0] OP_ERASE      = 4'd5;
  localparam logic [3:0] OP_READ       = 4'd6;
  localparam logic [3:0] OP_WRITE      = 4'd7;
  localparam logic [3:0] OP_CLEAR      = 4'd8;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_ALLOC   = 7'b0000010,
    S_WALK    = 7'b0000100,
    S_LINK_L  = 7'b0001000,
    S_LINK_LW = 7'b0010000,
    S_LINK_R  = 7'b0100000,
    S_LINK_RW = 7'b1000000
  } state_t;

endpackage

/* design/indexed_doubly_linked_list_unit.sv */
// ---------------------------------------------------------------------------
// Indexed doubly linked list unit
// A bounded list of signed 32-bit values kept in a node memory with links.
// ---------------------------------------------------------------------------
// A request (operation, position, item_value) is transferred at a rising edge
// with start high and busy low. Exactly one result follows: done is high for
// one cycle while status, read_value, element_count and list_empty hold it.
// The receiver cannot stall; the result must be taken in that cycle.
// Requests completed at once (bad index, full list, pop of an empty list,
// clear, unknown codes) raise done right after the transfer with busy staying
// low, and the next request can be taken at the following edge.
// Other requests walk the links from the head (from the tail for pop back;
// an insert or push at the end position skips the walk), one node per cycle,
// in a node memory with a registered read port. Inserts, pushes, erases and
// pops then relink the left neighbour and then the right one.
// The next request can be taken at the edge that ends the done cycle.
// Free slots are recycled through a stack memory and a fill mark, so reset
// needs no clearing pass: after reset the list is empty and the unit is idle.
// ---------------------------------------------------------------------------
module indexed_doubly_linked_list_unit #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         operation,
  input  logic [6:0]         position,
  input  logic signed [31:0] item_value,
  output logic               done,
  output logic [1:0]         status,
  output logic signed [31:0] read_value,
  output logic [6:0]         element_count,
  output logic               list_empty
);
  import idll_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int SW = $clog2(CAPACITY + 1);
  localparam int CW = SW;
  localparam int PW = (CW > 7) ? CW : 7;
  localparam int NW = 32 + 2 * SW;
  localparam logic [SW-1:0] NIL = SW'(CAPACITY);

  logic [NW-1:0] node_mem [CAPACITY];
  logic [AW-1:0] free_mem [CAPACITY];

  logic [NW-1:0] node_q;
  logic [AW-1:0] free_q;

  logic          node_we;
  logic [AW-1:0] node_waddr;
  logic [NW-1:0] node_wdata;
  logic [AW-1:0] node_raddr;
  logic          free_we;
  logic [AW-1:0] free_waddr;
  logic [AW-1:0] free_wdata;
  logic [AW-1:0] free_raddr;

  state_t        state, state_next;
  logic [3:0]    op, op_next;
  logic [31:0]   val, val_next;
  logic          need_walk, need_walk_next;
  logic [CW-1:0] rem, rem_next;
  logic [SW-1:0] cur, cur_next;
  logic [SW-1:0] slot, slot_next;
  logic [SW-1:0] lp, lp_next;
  logic [SW-1:0] rn, rn_next;
  logic [SW-1:0] lval, lval_next;
  logic [SW-1:0] rval, rval_next;
  logic [SW-1:0] head, head_next;
  logic [SW-1:0] tail, tail_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] hwm, hwm_next;
  logic [CW-1:0] ftop, ftop_next;
  logic          done_next;
  logic [1:0]    status_next;
  logic [31:0]   rdv, rdv_next;

  logic [31:0]   q_value;
  logic [SW-1:0] q_next;
  logic [SW-1:0] q_prev;
  logic [PW-1:0] cnt_x;
  logic [PW-1:0] pos_x;
  logic [PW-1:0] k_x;
  logic [SW-1:0] a_slot;
  logic [SW-1:0] w_start;

  assign q_value = node_q[NW-1 -: 32];
  assign q_next  = node_q[2*SW-1 -: SW];
  assign q_prev  = node_q[SW-1:0];
  assign cnt_x   = PW'(count);
  assign pos_x   = PW'(position);
  assign a_slot  = (ftop != '0) ? SW'(free_q) : hwm;

  assign busy          = (state != S_IDLE);
  assign read_value    = rdv;
  assign element_count = 7'(count);
  assign list_empty    = (count == '0);

  always_comb begin
    state_next     = state;
    op_next        = op;
    val_next       = val;
    need_walk_next = need_walk;
    rem_next       = rem;
    cur_next       = cur;
    slot_next      = slot;
    lp_next        = lp;
    rn_next        = rn;
    lval_next      = lval;
    rval_next      = rval;
    head_next      = head;
    tail_next      = tail;
    count_next     = count;
    hwm_next       = hwm;
    ftop_next      = ftop;
    done_next      = 1'b0;
    status_next    = status;
    rdv_next       = rdv;
    node_we        = 1'b0;
    node_waddr     = cur[AW-1:0];
    node_wdata     = node_q;
    node_raddr     = cur[AW-1:0];
    free_we        = 1'b0;
    free_waddr     = ftop[AW-1:0];
    free_wdata     = cur[AW-1:0];
    free_raddr     = AW'(ftop - 1'b1);
    k_x            = '0;
    w_start        = head;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          op_next  = operation;
          val_next = item_value;
          rdv_next = '0;
          case (operation) inside
            OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: begin
              if (operation == OP_PUSH_FRONT) begin
                k_x = '0;
              end else if (operation == OP_PUSH_BACK) begin
                k_x = cnt_x;
              end else begin
                k_x = pos_x;
              end
              if (k_x > cnt_x) begin
                done_next   = 1'b1;
                status_next = ST_RANGE;
              end else if (count == CW'(CAPACITY)) begin
                done_next   = 1'b1;
                status_next = ST_FULL;
              end else begin
                rem_next       = CW'(k_x);
                need_walk_next = (k_x < cnt_x);
                state_next     = S_ALLOC;
              end
            end
            OP_POP_FRONT, OP_POP_BACK, OP_ERASE: begin
              if (operation == OP_POP_BACK) begin
                w_start = tail;
              end
              if (count == '0 && operation != OP_ERASE) begin
                done_next   = 1'b1;
                status_next = ST_OK;
              end else if (operation == OP_ERASE && pos_x >= cnt_x) begin
                done_next   = 1'b1;
                status_next = ST_RANGE;
              end else begin
                node_raddr = w_start[AW-1:0];
                cur_next   = w_start;
                rem_next   = (operation == OP_ERASE) ? CW'(position) : '0;
                state_next = S_WALK;
              end
            end
            OP_READ, OP_WRITE: begin
              if (pos_x >= cnt_x) begin
                done_next   = 1'b1;
                status_next = ST_RANGE;
              end else begin
                node_raddr = head[AW-1:0];
                cur_next   = head;
                rem_next   = CW'(position);
                state_next = S_WALK;
              end
            end
            OP_CLEAR: begin
              head_next   = NIL;
              tail_next   = NIL;
              count_next  = '0;
              hwm_next    = '0;
              ftop_next   = '0;
              done_next   = 1'b1;
              status_next = ST_OK;
            end
            default: begin
              done_next   = 1'b1;
              status_next = ST_OK;
            end
          endcase
        end
      end

      S_ALLOC: begin
        slot_next = a_slot;
        if (ftop != '0) begin
          ftop_next = ftop - 1'b1;
        end else begin
          hwm_next = hwm + 1'b1;
        end
        if (need_walk) begin
          node_raddr = head[AW-1:0];
          cur_next   = head;
          state_next = S_WALK;
        end else begin
          node_we    = 1'b1;
          node_waddr = a_slot[AW-1:0];
          node_wdata = {val, NIL, tail};
          lp_next    = tail;
          rn_next    = NIL;
          lval_next  = a_slot;
          rval_next  = a_slot;
          count_next = count + 1'b1;
          state_next = S_LINK_L;
        end
      end

      S_WALK: begin
        if (rem == '0) begin
          case (op) inside
            OP_READ: begin
              rdv_next    = q_value;
              done_next   = 1'b1;
              status_next = ST_OK;
              state_next  = S_IDLE;
            end
            OP_WRITE: begin
              node_we     = 1'b1;
              node_waddr  = cur[AW-1:0];
              node_wdata  = {val, q_next, q_prev};
              done_next   = 1'b1;
              status_next = ST_OK;
              state_next  = S_IDLE;
            end
            OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: begin
              node_we    = 1'b1;
              node_waddr = slot[AW-1:0];
              node_wdata = {val, cur, q_prev};
              lp_next    = q_prev;
              rn_next    = cur;
              lval_next  = slot;
              rval_next  = slot;
              count_next = count + 1'b1;
              state_next = S_LINK_L;
            end
            OP_POP_FRONT, OP_POP_BACK, OP_ERASE: begin
              free_we    = 1'b1;
              free_waddr = ftop[AW-1:0];
              free_wdata = cur[AW-1:0];
              ftop_next  = ftop + 1'b1;
              lp_next    = q_prev;
              rn_next    = q_next;
              lval_next  = q_next;
              rval_next  = q_prev;
              count_next = count - 1'b1;
              state_next = S_LINK_L;
            end
            default: begin
              done_next   = 1'b1;
              status_next = ST_OK;
              state_next  = S_IDLE;
            end
          endcase
        end else begin
          rem_next   = rem - 1'b1;
          cur_next   = q_next;
          node_raddr = q_next[AW-1:0];
        end
      end

      S_LINK_L: begin
        if (lp != NIL) begin
          node_raddr = lp[AW-1:0];
          state_next = S_LINK_LW;
        end else begin
          head_next  = lval;
          state_next = S_LINK_R;
        end
      end

      S_LINK_LW: begin
        node_we    = 1'b1;
        node_waddr = lp[AW-1:0];
        node_wdata = {q_value, lval, q_prev};
        state_next = S_LINK_R;
      end

      S_LINK_R: begin
        if (rn != NIL) begin
          node_raddr = rn[AW-1:0];
          state_next = S_LINK_RW;
        end else begin
          tail_next   = rval;
          done_next   = 1'b1;
          status_next = ST_OK;
          state_next  = S_IDLE;
        end
      end

      S_LINK_RW: begin
        node_we     = 1'b1;
        node_waddr  = rn[AW-1:0];
        node_wdata  = {q_value, q_next, rval};
        done_next   = 1'b1;
        status_next = ST_OK;
        state_next  = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    node_q <= node_mem[node_raddr];
    if (free_we) begin
      free_mem[free_waddr] <= free_wdata;
    end
    free_q <= free_mem[free_raddr];
  end

  always_ff @(posedge clk) begin
    op        <= op_next;
    val       <= val_next;
    need_walk <= need_walk_next;
    rem       <= rem_next;
    cur       <= cur_next;
    slot      <= slot_next;
    lp        <= lp_next;
    rn        <= rn_next;
    lval      <= lval_next;
    rval      <= rval_next;
    status    <= status_next;
    rdv       <= rdv_next;
    if (rst) begin
      state <= S_IDLE;
      head  <= NIL;
      tail  <= NIL;
      count <= '0;
      hwm   <= '0;
      ftop  <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
      hwm   <= hwm_next;
      ftop  <= ftop_next;
      done  <= done_next;
    end
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe raised while a request is still in progress");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("element count exceeds capacity");

  a_slot_accounting: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (CW'(hwm - ftop) == count))
    else $error("allocated slots disagree with element count");

  a_empty_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && count == '0) |-> (head == NIL && tail == NIL))
    else $error("empty list still has a head or tail slot");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (count == CW'(CAPACITY)))
    else $error("full status reported while slots remain");
`endif

endmodule

/* test/tb_indexed_doubly_linked_list_unit.sv */
// ---------------------------------------------------------------------------
// Indexed doubly linked list unit testbench
// Drives list requests through the start/busy handshake and checks every
// result strobe against a behavioral list kept in the testbench. A short
// directed part covers empty-list requests, extreme values, indexing at the
// ends and unused operation codes. Random traffic then alternates growing and
// shrinking the list so that the full condition is reached many times.
// ---------------------------------------------------------------------------
module tb_indexed_doubly_linked_list_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import idll_pkg::*;

  localparam int          CAPACITY        = 64;
  localparam logic [6:0]  NIL_SLOT        = 7'd64;
  localparam logic [3:0]  OP_UNUSED_FIRST = 4'd9;
  localparam logic [3:0]  OP_UNUSED_LAST  = 4'd15;
  localparam int          HALF_PERIOD     = 10;
  localparam int          RESET_CYCLES    = 5;
  localparam int          WATCHDOG_LIMIT  = 2000;
  localparam int          DRAIN_CYCLES    = 100;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_value;
    logic [6:0]  element_count;
    logic        list_empty;
  } list_response_t;

  logic               clk        = 1'b0;
  logic               rst        = 1'b1;
  logic               start      = 1'b0;
  logic [3:0]         operation  = '0;
  logic [6:0]         position   = '0;
  logic signed [31:0] item_value = '0;
  logic               busy;
  logic               done;
  logic [1:0]         status;
  logic signed [31:0] read_value;
  logic [6:0]         element_count;
  logic               list_empty;

  logic [31:0]         stored_value [CAPACITY];
  logic [6:0]          next_slot [CAPACITY];
  logic [6:0]          prev_slot [CAPACITY];
  logic [CAPACITY-1:0] slot_taken = '0;
  logic [6:0]          list_head  = NIL_SLOT;
  logic [6:0]          list_tail  = NIL_SLOT;
  int unsigned         list_count = 0;

  list_response_t responses_due [$];
  list_response_t oldest_due;
  int unsigned    mismatch_count  = 0;
  int unsigned    stall_cycles    = 0;
  int unsigned    sender_idle_pct = 0;

  indexed_doubly_linked_list_unit #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .position     (position),
    .item_value   (item_value),
    .done         (done),
    .status       (status),
    .read_value   (read_value),
    .element_count(element_count),
    .list_empty   (list_empty)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  function automatic logic [6:0] slot_at(input int unsigned k);
    logic [6:0] s;
    s = list_head;
    for (int unsigned i = 0; i < k; i++) begin
      if (s == NIL_SLOT) return NIL_SLOT;
      s = next_slot[s];
    end
    return s;
  endfunction

  function automatic void clear_list();
    slot_taken = '0;
    list_head  = NIL_SLOT;
    list_tail  = NIL_SLOT;
    list_count = 0;
  endfunction

  function automatic logic [1:0] list_insert(input int unsigned k, input logic [31:0] v);
    logic [6:0] s;
    logic [6:0] succ;
    logic [6:0] pred;
    if (k > list_count) return ST_RANGE;
    if (list_count >= CAPACITY) return ST_FULL;
    s = NIL_SLOT;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!slot_taken[i]) s = 7'(i);
    end
    if (k < list_count) begin
      succ = slot_at(k);
      pred = prev_slot[succ];
    end else begin
      succ = NIL_SLOT;
      pred = list_tail;
    end
    stored_value[s] = v;
    next_slot[s]    = succ;
    prev_slot[s]    = pred;
    slot_taken[s]   = 1'b1;
    if (pred == NIL_SLOT) list_head = s;
    else next_slot[pred] = s;
    if (succ == NIL_SLOT) list_tail = s;
    else prev_slot[succ] = s;
    list_count++;
    return ST_OK;
  endfunction

  function automatic logic [1:0] list_erase(input int unsigned k);
    logic [6:0] s;
    logic [6:0] p;
    logic [6:0] n;
    if (k >= list_count) return ST_RANGE;
    s = slot_at(k);
    p = prev_slot[s];
    n = next_slot[s];
    if (p == NIL_SLOT) list_head = n;
    else next_slot[p] = n;
    if (n == NIL_SLOT) list_tail = p;
    else prev_slot[n] = p;
    slot_taken[s] = 1'b0;
    list_count--;
    if (list_count == 0) begin
      list_head = NIL_SLOT;
      list_tail = NIL_SLOT;
    end
    return ST_OK;
  endfunction

  function automatic list_response_t predict_response(input logic [3:0] op,
                                                      input logic [6:0] pos,
                                                      input logic [31:0] val);
    list_response_t r;
    r.status     = ST_OK;
    r.read_value = '0;
    case (op)
      OP_PUSH_FRONT: r.status = list_insert(0, val);
      OP_PUSH_BACK:  r.status = list_insert(list_count, val);
      OP_POP_FRONT: begin
        if (list_count > 0) r.status = list_erase(0);
      end
      OP_POP_BACK: begin
        if (list_count > 0) r.status = list_erase(list_count - 1);
      end
      OP_INSERT: r.status = list_insert(pos, val);
      OP_ERASE:  r.status = list_erase(pos);
      OP_READ: begin
        if (pos >= list_count) r.status = ST_RANGE;
        else r.read_value = stored_value[slot_at(pos)];
      end
      OP_WRITE: begin
        if (pos >= list_count) r.status = ST_RANGE;
        else stored_value[slot_at(pos)] = val;
      end
      OP_CLEAR: clear_list();
      default: ;
    endcase
    r.element_count = 7'(list_count);
    r.list_empty    = (list_count == 0);
    return r;
  endfunction

  task automatic send_request(input logic [3:0] op, input logic [6:0] pos,
                              input logic [31:0] val);
    if ($urandom_range(99) < sender_idle_pct) begin
      start      <= 1'b0;
      operation  <= 4'($urandom);
      position   <= 7'($urandom);
      item_value <= $urandom;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start      <= 1'b1;
    operation  <= op;
    position   <= pos;
    item_value <= val;
    do @(posedge clk); while (busy);
    responses_due.push_back(predict_response(op, pos, val));
  endtask

  task automatic test_empty_list_requests();
    send_request(OP_POP_FRONT, 7'd0, 32'h0000_0001);
    send_request(OP_POP_BACK, 7'd0, 32'h0000_0002);
    send_request(OP_READ, 7'd0, 32'h0000_0000);
    send_request(OP_WRITE, 7'd0, 32'h5555_5555);
    send_request(OP_ERASE, 7'd0, 32'h0000_0000);
    send_request(OP_INSERT, 7'd1, 32'hAAAA_AAAA);
    send_request(OP_INSERT, 7'd127, 32'hFFFF_FFFF);
  endtask

  task automatic test_edge_values_and_indexing();
    send_request(OP_INSERT, 7'd0, 32'h0000_0000);
    send_request(OP_PUSH_FRONT, 7'd0, 32'h7FFF_FFFF);
    send_request(OP_PUSH_BACK, 7'd0, 32'h8000_0000);
    send_request(OP_PUSH_BACK, 7'd127, 32'hFFFF_FFFF);
    for (int k = 0; k < 5; k++) send_request(OP_READ, 7'(k), 32'h0000_0000);
    send_request(OP_WRITE, 7'd2, 32'h1234_5678);
    send_request(OP_READ, 7'd2, 32'h0000_0000);
    send_request(OP_ERASE, 7'd4, 32'h0000_0000);
    send_request(OP_INSERT, 7'd4, 32'h0000_0001);
    send_request(OP_ERASE, 7'd2, 32'h0000_0000);
    send_request(OP_POP_FRONT, 7'd0, 32'h0000_0000);
    send_request(OP_POP_BACK, 7'd0, 32'h0000_0000);
  endtask

  task automatic test_clear_and_unused_codes();
    send_request(OP_UNUSED_FIRST, 7'd127, 32'hFFFF_FFFF);
    send_request(OP_UNUSED_LAST, 7'd0, 32'h0000_0000);
    send_request(OP_CLEAR, 7'd127, 32'hFFFF_FFFF);
    send_request(OP_READ, 7'd0, 32'h0000_0000);
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned n_items);
    int unsigned sent;
    int unsigned r;
    bit          grow;
    logic [3:0]  op;
    logic [6:0]  pos;
    sender_idle_pct = idle_pct;
    sent = 0;
    grow = 1'b1;
    while (sent < n_items) begin
      if (list_count == CAPACITY && $urandom_range(3) == 0) grow = 1'b0;
      else if (list_count == 0) grow = 1'b1;
      else if ($urandom_range(99) == 0) grow = !grow;
      r = $urandom_range(99);
      if (grow) begin
        op = r < 20 ? OP_PUSH_FRONT : r < 40 ? OP_PUSH_BACK : r < 65 ? OP_INSERT :
             r < 72 ? OP_ERASE : r < 77 ? OP_POP_FRONT : r < 80 ? OP_POP_BACK :
             r < 89 ? OP_READ : r < 98 ? OP_WRITE :
             4'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
      end else begin
        op = r < 15 ? OP_POP_FRONT : r < 30 ? OP_POP_BACK : r < 55 ? OP_ERASE :
             r < 60 ? OP_PUSH_FRONT : r < 65 ? OP_PUSH_BACK : r < 70 ? OP_INSERT :
             r < 82 ? OP_READ : r < 94 ? OP_WRITE : r < 97 ? OP_CLEAR :
             4'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
      end
      r = $urandom_range(9);
      if (r < 7) pos = 7'($urandom_range(0, list_count));
      else if (r == 7) pos = 7'(list_count);
      else if (r == 8) pos = 7'(list_count + 1);
      else pos = 7'($urandom);
      send_request(op, pos, $urandom);
      if (op <= OP_CLEAR) sent++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (responses_due.size() == 0) begin
        $error("result strobe with no request outstanding");
        mismatch_count++;
      end else begin
        oldest_due = responses_due.pop_front();
        if (status !== oldest_due.status) begin
          $error("status: expected %0d, actual %0d", oldest_due.status, status);
          mismatch_count++;
        end
        if (read_value !== oldest_due.read_value) begin
          $error("read_value: expected %0d, actual %0d",
                 $signed(oldest_due.read_value), read_value);
          mismatch_count++;
        end
        if (element_count !== oldest_due.element_count) begin
          $error("element_count: expected %0d, actual %0d",
                 oldest_due.element_count, element_count);
          mismatch_count++;
        end
        if (list_empty !== oldest_due.list_empty) begin
          $error("list_empty: expected %0d, actual %0d", oldest_due.list_empty, list_empty);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_empty_list_requests();
    test_edge_values_and_indexing();
    test_clear_and_unused_codes();
    test_random_traffic(22, 340);
    test_random_traffic(72, 340);
    test_random_traffic(0, 345);
    start <= 1'b0;
    while (responses_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
